[rtl/shifted_window_hamming_distance_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the shifted-window Hamming distance block
// Same-cycle and next-cycle implication checks, with reset disable.
// ----------------------------------------------------------------------------
`ifndef SHIFTED_WINDOW_HAMMING_DISTANCE_ASSERT_SVH
`define SHIFTED_WINDOW_HAMMING_DISTANCE_ASSERT_SVH

// Antecedent implies consequent in the same cycle
`define SWHD_ASSERT_IMPLIES(name, clk, rstn, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("swhd assertion failed");

// Antecedent implies consequent in the following cycle
`define SWHD_ASSERT_NEXT(name, clk, rstn, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("swhd assertion failed");

`endif

[rtl/swhd_pkg.sv]
// ----------------------------------------------------------------------------
// swhd_pkg
// Widths and constants shared by the shifted-window Hamming distance block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package swhd_pkg;

  // Field widths
  localparam int unsigned WORD_W  = 64;
  localparam int unsigned SHIFT_W = 6;
  localparam int unsigned LEN_W   = 13;
  localparam int unsigned DIST_W  = 13;

  // Reset value of the pattern length register
  localparam logic [LEN_W-1:0] LEN_RESET = 13'd64;

  // Default pattern size limit and the largest value a distance can hold
  localparam int unsigned MAX_PATTERN_BITS_DEF = 4096;
  localparam int unsigned WIDTH_MAX            = 8191;

  typedef logic [WORD_W-1:0]  word_t;
  typedef logic [SHIFT_W-1:0] shift_t;
  typedef logic [LEN_W-1:0]   len_t;
  typedef logic [DIST_W-1:0]  dist_t;

endpackage

`default_nettype wire

[rtl/swhd_if.sv]
// ----------------------------------------------------------------------------
// swhd channel interfaces
// Valid/ready channels for input words, results and the length register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

// Input word channel
interface swhd_in_if;
  logic                  valid;
  logic                  ready;
  swhd_pkg::word_t       pattern_word;
  swhd_pkg::word_t       ref_word;
  swhd_pkg::word_t       ref_next_word;
  swhd_pkg::shift_t      shift_amount;
  logic                  beyond_end;
  logic                  tail_word;

  modport source (output valid, pattern_word, ref_word, ref_next_word, shift_amount,
                  beyond_end, tail_word, input ready);
  modport sink   (input valid, pattern_word, ref_word, ref_next_word, shift_amount,
                  beyond_end, tail_word, output ready);
endinterface

// Result channel
interface swhd_out_if;
  logic                  valid;
  logic                  ready;
  swhd_pkg::dist_t       distance;

  modport source (output valid, distance, input ready);
  modport sink   (input valid, distance, output ready);
endinterface

// Pattern length write channel
interface swhd_cfg_if;
  logic                  valid;
  logic                  ready;
  swhd_pkg::len_t        data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

`default_nettype wire

[rtl/shifted_window_hamming_distance.sv]
// ----------------------------------------------------------------------------
// shifted_window_hamming_distance
// Hamming distance between a pattern and a bit-shifted reference window.
// ----------------------------------------------------------------------------
// Takes one request per clock: each carries a 64-bit pattern word, the two
// reference words under it and the window's bit offset. Requests land in an
// input register; the funnel shift, XOR, 64-bit popcount and saturating
// accumulate then run combinationally into the running total, and a last-word
// request loads the result register. A result passes the input register and
// then the result register once its last word is taken. Throughput is one
// word per cycle, set by the popcount-plus-accumulate path; it drops only
// while a finished result waits on the output and the next last word is
// queued behind it. The user must write pattern_length through the cfg
// channel while no comparison is in flight; the block does not enforce it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "shifted_window_hamming_distance_assert.svh"

module shifted_window_hamming_distance #(
  parameter int unsigned MAX_PATTERN_BITS = swhd_pkg::MAX_PATTERN_BITS_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  swhd_in_if.sink         in_if,
  swhd_out_if.source      out_if,
  swhd_cfg_if.sink        cfg_if
);

  localparam int unsigned W      = swhd_pkg::WORD_W;
  localparam int unsigned SW     = swhd_pkg::SHIFT_W;
  localparam int unsigned DW     = swhd_pkg::DIST_W;
  localparam int unsigned CW     = $clog2(W + 1);
  localparam int unsigned CAP    = (MAX_PATTERN_BITS < swhd_pkg::WIDTH_MAX) ?
                                   MAX_PATTERN_BITS : swhd_pkg::WIDTH_MAX;
  localparam logic [DW:0] CAP_V  = (DW + 1)'(CAP);

  // Input stage
  logic                  s1_valid_r, s1_valid_nxt;
  swhd_pkg::word_t       s1_pat_r, s1_cur_r, s1_nxt_r;
  swhd_pkg::shift_t      s1_shift_r;
  logic                  s1_beyond_r, s1_last_r;

  // State
  swhd_pkg::len_t        pat_len_r, pat_len_nxt;
  swhd_pkg::dist_t       run_dist_r, run_dist_nxt;
  logic                  out_valid_r, out_valid_nxt;
  swhd_pkg::dist_t       out_dist_r;

  // Datapath
  logic [2*W-1:0]        funnel;
  swhd_pkg::word_t       aligned, lo_mask, diff;
  logic [SW-1:0]         rem;
  logic [CW-1:0]         ones;
  logic [DW:0]           sum;
  swhd_pkg::dist_t       sat_sum, result;
  logic                  out_free, s1_adv, in_take;

  // Align, compare, trim the last word
  always_comb begin
    funnel  = {s1_nxt_r, s1_cur_r} >> s1_shift_r;
    aligned = funnel[W-1:0];
    rem     = pat_len_r[SW-1:0];
    lo_mask = (rem == '0) ? '1 : ((W'(1) << rem) - W'(1));
    diff    = s1_pat_r ^ aligned;
    if (s1_last_r) begin
      diff = diff & lo_mask;
    end
  end

  swhd_popcnt #(.W(W)) u_popcnt (
    .bits_i  (diff),
    .count_o (ones)
  );

  // Saturating accumulate and result select
  always_comb begin
    sum     = {1'b0, run_dist_r} + (DW + 1)'(ones);
    sat_sum = (sum > CAP_V) ? CAP_V[DW-1:0] : sum[DW-1:0];
    result  = s1_beyond_r ? pat_len_r : sat_sum;
  end

  // Handshake
  assign out_free     = !out_valid_r || out_if.ready;
  assign s1_adv       = s1_valid_r && (!s1_last_r || out_free);
  assign in_if.ready  = !s1_valid_r || s1_adv;
  assign in_take      = in_if.valid && in_if.ready;
  assign cfg_if.ready = 1'b1;
  assign out_if.valid    = out_valid_r;
  assign out_if.distance = out_dist_r;

  // Next state
  always_comb begin
    s1_valid_nxt  = s1_valid_r;
    run_dist_nxt  = run_dist_r;
    out_valid_nxt = out_valid_r;
    pat_len_nxt   = pat_len_r;
    if (s1_adv) begin
      s1_valid_nxt = 1'b0;
      run_dist_nxt = s1_last_r ? '0 : sat_sum;
    end
    if (in_take) begin
      s1_valid_nxt = 1'b1;
    end
    if (out_if.ready) begin
      out_valid_nxt = 1'b0;
    end
    if (s1_adv && s1_last_r) begin
      out_valid_nxt = 1'b1;
    end
    if (cfg_if.valid) begin
      pat_len_nxt = cfg_if.data;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      run_dist_r  <= '0;
      out_valid_r <= 1'b0;
      pat_len_r   <= swhd_pkg::LEN_RESET;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      run_dist_r  <= run_dist_nxt;
      out_valid_r <= out_valid_nxt;
      pat_len_r   <= pat_len_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_pat_r    <= in_if.pattern_word;
      s1_cur_r    <= in_if.ref_word;
      s1_nxt_r    <= in_if.ref_next_word;
      s1_shift_r  <= in_if.shift_amount;
      s1_beyond_r <= in_if.beyond_end;
      s1_last_r   <= in_if.tail_word;
    end
    if (s1_adv && s1_last_r) begin
      out_dist_r <= result;
    end
  end

  // Checks
  `SWHD_ASSERT_NEXT(a_total_clears, clk, rst_n, s1_adv && s1_last_r, run_dist_r == '0)
  `SWHD_ASSERT_NEXT(a_result_loads, clk, rst_n, s1_adv && s1_last_r, out_valid_r)
  `SWHD_ASSERT_IMPLIES(a_total_capped, clk, rst_n, 1'b1, run_dist_r <= CAP_V[DW-1:0])
  `SWHD_ASSERT_IMPLIES(a_stall_holds, clk, rst_n, s1_valid_r && s1_last_r && !out_free, !in_if.ready)

endmodule

`default_nettype wire

[rtl/swhd_popcnt.sv]
// ----------------------------------------------------------------------------
// swhd_popcnt
// Adder-tree population count of one word.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module swhd_popcnt #(
  parameter int unsigned W = swhd_pkg::WORD_W,
  localparam int unsigned CW = $clog2(W + 1),
  localparam int unsigned LV = $clog2(W),
  localparam int unsigned NP = 1 << LV
) (
  input  logic [W-1:0]  bits_i,
  output logic [CW-1:0] count_o
);

  logic [CW-1:0] node [0:LV][0:NP-1];

  // Pairwise sums, one tree level at a time
  always_comb begin
    for (int l = 0; l <= LV; l++) begin
      for (int i = 0; i < NP; i++) begin
        node[l][i] = '0;
      end
    end
    for (int i = 0; i < W; i++) begin
      node[0][i] = CW'(bits_i[i]);
    end
    for (int l = 1; l <= LV; l++) begin
      for (int i = 0; i < (NP >> l); i++) begin
        node[l][i] = node[l-1][2*i] + node[l-1][2*i+1];
      end
    end
    count_o = node[LV][0];
  end

endmodule

`default_nettype wire

[dv/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the shifted-window Hamming distance block. A queue
// of word requests feeds a clocked driver; a local predictor models the
// funnel shift, XOR, popcount, saturating total and last-word masking, and a
// clocked monitor checks each distance against the oldest prediction. The
// pattern length register is rewritten between phases while the block idles.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;

  localparam int unsigned MAX_BITS  = swhd_pkg::MAX_PATTERN_BITS_DEF;
  localparam int unsigned DIST_CAP  = (MAX_BITS < swhd_pkg::WIDTH_MAX) ? MAX_BITS :
                                      swhd_pkg::WIDTH_MAX;
  localparam int unsigned NUM_PHASES      = 12;
  localparam int unsigned WORDS_PER_PHASE = 85;
  localparam int unsigned SETTLE_CYCLES   = 8;
  localparam int unsigned STALL_LIMIT     = 4000;  // cycles without any handshake

  typedef struct packed {
    swhd_pkg::word_t  pattern_word;
    swhd_pkg::word_t  ref_word;
    swhd_pkg::word_t  ref_next_word;
    swhd_pkg::shift_t shift_amount;
    logic             beyond_end;
    logic             tail_word;
  } word_req_t;

  logic clk;
  logic rst_n;

  swhd_in_if  in_if ();
  swhd_out_if out_if ();
  swhd_cfg_if cfg_if ();

  shifted_window_hamming_distance #(
    .MAX_PATTERN_BITS(MAX_BITS)
  ) i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_if),
    .out_if (out_if),
    .cfg_if (cfg_if)
  );

  word_req_t         pending_words[$];
  swhd_pkg::dist_t   expected_distances[$];
  word_req_t         driven_word = '0;
  swhd_pkg::len_t    pattern_length_q;
  int unsigned       running_total = 0;
  int unsigned       send_idle_pct;
  int unsigned       recv_stall_pct;
  int unsigned       error_count = 0;
  int unsigned       quiet_cycles;

  // Clock
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Window alignment: low bits from the current word, high bits from the next
  function automatic swhd_pkg::word_t align_window(swhd_pkg::word_t cur,
                                                   swhd_pkg::word_t nxt,
                                                   swhd_pkg::shift_t sh);
    if (sh == '0) begin
      return cur;
    end
    return (cur >> sh) | (nxt << (swhd_pkg::WORD_W - sh));
  endfunction

  function automatic int unsigned capped_sum(int unsigned a, int unsigned b);
    int unsigned s;
    s = a + b;
    return (s > DIST_CAP) ? DIST_CAP : s;
  endfunction

  // Predictor: fold one accepted request into the total, queue a distance on last
  task automatic accumulate_word(word_req_t w);
    swhd_pkg::word_t diff;
    int unsigned     rem;
    diff = w.pattern_word ^ align_window(w.ref_word, w.ref_next_word, w.shift_amount);
    if (!w.tail_word) begin
      running_total = capped_sum(running_total, $countones(diff));
    end else if (w.beyond_end) begin
      expected_distances.push_back(swhd_pkg::dist_t'(pattern_length_q));
      running_total = 0;
    end else begin
      rem = int'(pattern_length_q[5:0]);
      if (rem != 0) begin
        diff &= (swhd_pkg::word_t'(1) << rem) - swhd_pkg::word_t'(1);
      end
      expected_distances.push_back(
        swhd_pkg::dist_t'(capped_sum(running_total, $countones(diff))));
      running_total = 0;
    end
  endtask

  function automatic swhd_pkg::word_t rand_word();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 5) begin
      return '0;
    end
    if (pick < 10) begin
      return '1;
    end
    return {$urandom(), $urandom()};
  endfunction

  task automatic push_word(swhd_pkg::word_t pat, swhd_pkg::word_t cur,
                           swhd_pkg::word_t nxt, swhd_pkg::shift_t sh,
                           logic beyond, logic last);
    word_req_t w;
    w.pattern_word  = pat;
    w.ref_word      = cur;
    w.ref_next_word = nxt;
    w.shift_amount  = sh;
    w.beyond_end    = beyond;
    w.tail_word     = last;
    pending_words.push_back(w);
  endtask

  // One comparison of n_words requests; saturate makes every bit differ
  task automatic queue_comparison(int unsigned n_words, bit saturate);
    word_req_t       w;
    swhd_pkg::word_t aligned;
    int unsigned     pick;
    for (int unsigned k = 0; k < n_words; k++) begin
      w.ref_word      = rand_word();
      w.ref_next_word = rand_word();
      pick = $urandom_range(99);
      w.shift_amount  = (pick < 20) ? swhd_pkg::shift_t'(0) :
                        (pick < 30) ? swhd_pkg::shift_t'(63) :
                                      swhd_pkg::shift_t'($urandom_range(63));
      aligned = align_window(w.ref_word, w.ref_next_word, w.shift_amount);
      pick = $urandom_range(99);
      if (saturate || pick < 10) begin
        w.pattern_word = ~aligned;
      end else if (pick < 30) begin
        w.pattern_word = aligned;
      end else if (pick < 50) begin
        w.pattern_word = aligned ^ (swhd_pkg::word_t'(1) << $urandom_range(63))
                                 ^ (swhd_pkg::word_t'(1) << $urandom_range(63));
      end else begin
        w.pattern_word = rand_word();
      end
      w.tail_word  = (k == n_words - 1);
      // beyond_end on a middle word is noise the block ignores
      w.beyond_end = w.tail_word ? ($urandom_range(99) < 10 && !saturate)
                                 : ($urandom_range(99) < 25);
      pending_words.push_back(w);
    end
  endtask

  // Block the stimulus until every request is taken and every distance is back
  task automatic wait_drained();
    do begin
      @(posedge clk);
    end while (pending_words.size() != 0 || in_if.valid || expected_distances.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_length(swhd_pkg::len_t value);
    @(posedge clk);
    cfg_if.valid <= 1'b1;
    cfg_if.data  <= value;
    do begin
      @(posedge clk);
    end while (!cfg_if.ready);
    cfg_if.valid     <= 1'b0;
    pattern_length_q  = value;
  endtask

  // Driver: present queued requests, with random idle cycles
  always @(posedge clk) begin
    if (!rst_n) begin
      in_if.valid <= 1'b0;
    end else begin
      if (in_if.valid && in_if.ready) begin
        accumulate_word(driven_word);
      end
      if (!in_if.valid || in_if.ready) begin
        if (pending_words.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          driven_word          <= pending_words[0];
          in_if.pattern_word   <= pending_words[0].pattern_word;
          in_if.ref_word       <= pending_words[0].ref_word;
          in_if.ref_next_word  <= pending_words[0].ref_next_word;
          in_if.shift_amount   <= pending_words[0].shift_amount;
          in_if.beyond_end     <= pending_words[0].beyond_end;
          in_if.tail_word      <= pending_words[0].tail_word;
          in_if.valid          <= 1'b1;
          void'(pending_words.pop_front());
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each distance against the oldest prediction
  always @(posedge clk) begin
    swhd_pkg::dist_t want;
    if (!rst_n) begin
      out_if.ready <= 1'b0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        if (expected_distances.size() == 0) begin
          $error("distance: expected none, actual %0d", out_if.distance);
          error_count++;
        end else begin
          want = expected_distances.pop_front();
          if (out_if.distance !== want) begin
            $error("distance: expected %0d, actual %0d", want, out_if.distance);
            error_count++;
          end
        end
      end
      out_if.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Watchdog on cycles with no handshake on any channel
  always @(posedge clk) begin
    if (!rst_n) begin
      quiet_cycles = 0;
    end else if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
                 (cfg_if.valid && cfg_if.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("testbench NOT OK");
        $finish;
      end
    end
  end

  // Stimulus
  initial begin
    swhd_pkg::word_t a_cur;
    swhd_pkg::word_t a_nxt;
    swhd_pkg::len_t  len;
    int unsigned     queued;
    int unsigned     pick;
    int unsigned     n_words;

    rst_n               = 1'b0;
    cfg_if.valid        = 1'b0;
    cfg_if.data         = '0;
    pattern_length_q    = swhd_pkg::LEN_RESET;
    send_idle_pct       = 7;
    recv_stall_pct      = 86;

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: reset length of 64, so the last word counts in full
    push_word('0, '0, '0, 6'd0, 1'b0, 1'b1);
    push_word('1, '0, '0, 6'd0, 1'b0, 1'b1);
    push_word('0, '0, '1, 6'd63, 1'b0, 1'b1);
    // beyond_end ignored mid-comparison, then honored on the last word
    push_word(rand_word(), rand_word(), rand_word(), 6'd1, 1'b1, 1'b0);
    push_word(rand_word(), rand_word(), rand_word(), 6'd62, 1'b1, 1'b1);
    push_word(rand_word(), rand_word(), rand_word(), 6'd32, 1'b0, 1'b0);
    push_word(rand_word(), rand_word(), rand_word(), 6'd32, 1'b0, 1'b0);
    push_word(rand_word(), rand_word(), rand_word(), 6'd32, 1'b0, 1'b1);
    a_cur = {$urandom(), $urandom()};
    a_nxt = {$urandom(), $urandom()};
    push_word(align_window(a_cur, a_nxt, 6'd17), a_cur, a_nxt, 6'd17, 1'b0, 1'b1);
    wait_drained();

    // Shortest pattern: only bit 0 of the last word counts
    write_length(swhd_pkg::len_t'(1));
    push_word(swhd_pkg::word_t'(1), '0, '0, 6'd0, 1'b0, 1'b1);
    push_word(~swhd_pkg::word_t'(1), '0, '0, 6'd0, 1'b0, 1'b1);
    wait_drained();

    // Zero length: full last word, beyond_end returns zero
    write_length(swhd_pkg::len_t'(0));
    push_word('1, '0, '0, 6'd0, 1'b0, 1'b1);
    push_word('0, '0, '0, 6'd0, 1'b1, 1'b1);
    wait_drained();

    // Largest register value: beyond_end returns it, mask keeps 63 bits
    write_length('1);
    push_word('0, '0, '0, 6'd0, 1'b1, 1'b1);
    push_word('1, '0, '0, 6'd0, 1'b0, 1'b1);
    wait_drained();

    // Random phases, each under its own pattern length
    for (int unsigned p = 0; p < NUM_PHASES; p++) begin
      if (p < 4) begin
        send_idle_pct  = 7;
        recv_stall_pct = 86;
      end else if (p < 8) begin
        send_idle_pct  = 86;
        recv_stall_pct = 7;
      end else begin
        send_idle_pct  = 0;
        recv_stall_pct = 0;
      end
      case (p)
        0:       len = swhd_pkg::len_t'(1);
        1:       len = swhd_pkg::len_t'(4096);
        2:       len = swhd_pkg::len_t'(0);
        3:       len = '1;
        4:       len = swhd_pkg::len_t'(63);
        5:       len = swhd_pkg::len_t'(65);
        6:       len = swhd_pkg::len_t'(64);
        7:       len = swhd_pkg::len_t'(127);
        11:      len = swhd_pkg::len_t'($urandom_range(8191));
        default: len = swhd_pkg::len_t'($urandom_range(4096, 1));
      endcase
      write_length(len);

      queued = 0;
      // a long all-different run drives the total into saturation
      if (p == 1) begin
        n_words = $urandom_range(72, 66);
        queue_comparison(n_words, 1'b1);
        queued += n_words;
      end
      while (queued < WORDS_PER_PHASE) begin
        pick = $urandom_range(99);
        if (pick < 70) begin
          n_words = $urandom_range(4, 1);
          queue_comparison(n_words, 1'b0);
        end else if (pick < 90) begin
          n_words = (len + 63) / 64;
          n_words = (n_words == 0) ? 1 : (n_words > 8) ? 8 : n_words;
          queue_comparison(n_words, 1'b0);
        end else if (pick < 98) begin
          n_words = $urandom_range(20, 9);
          queue_comparison(n_words, 1'b0);
        end else begin
          n_words = $urandom_range(72, 66);
          queue_comparison(n_words, 1'b1);
        end
        queued += n_words;
      end
      wait_drained();
    end

    if (error_count == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule
